// ===== rtl/core/bds_pkg.sv =====
package bds_pkg;

  // Sizes of the frame, the block and the line buffer
  localparam int unsigned MaxWidth    = 4096;
  localparam int unsigned MaxFactor   = 16;
  localparam int unsigned HeightLimit = 4096;

  localparam int unsigned DimW   = 13;  // frame_width / frame_height registers
  localparam int unsigned FactW  = 5;   // scale_factor register
  localparam int unsigned PosW   = 12;  // pixel and block positions
  localparam int unsigned CntW   = 4;   // position inside a block
  localparam int unsigned PixW   = 8;
  localparam int unsigned SumW   = 16;  // one channel of a block sum
  localparam int unsigned AreaW  = 9;   // factor squared
  localparam int unsigned DivNW  = 16;  // divider dividend / quotient
  localparam int unsigned DivDW  = 13;  // divider divisor / remainder
  localparam int unsigned DivCntW = 5;
  localparam int unsigned RamAw  = $clog2(MaxWidth);
  localparam int unsigned RamW   = 3 * SumW;

  localparam logic [DimW-1:0]  WidthReset  = 13'd640;
  localparam logic [DimW-1:0]  HeightReset = 13'd480;
  localparam logic [FactW-1:0] FactorReset = 5'd1;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_FACTOR = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_WIDTH  = 3'd0,
    OP_HEIGHT = 3'd1,
    OP_RED    = 3'd2,
    OP_GREEN  = 3'd3,
    OP_BLUE   = 3'd4
  } div_op_e;

  typedef struct packed {
    logic    accept;
    logic    ram_we;
    logic    div_start;
    div_op_e div_op;
    logic    div_capture;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cfg_hit;
    logic pix_used;
    logic last;
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/bds_ram.sv =====
module bds_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bds_div.sv =====
module bds_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bds_pkg::DivNW-1:0]  dividend_i,
  input  logic [bds_pkg::DivDW-1:0]  divisor_i,
  output logic                       busy_o,
  output logic [bds_pkg::DivNW-1:0]  quotient_o,
  output logic [bds_pkg::DivDW-1:0]  remainder_o
);

  logic [bds_pkg::DivNW-1:0]   quo_q, quo_d;
  logic [bds_pkg::DivDW-1:0]   rem_q, rem_d;
  logic [bds_pkg::DivCntW-1:0] cnt_q;
  logic                        busy_q;
  logic [bds_pkg::DivDW:0]     trial;
  logic [bds_pkg::DivDW:0]     diff;
  logic                        fits;

  // One quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_q, quo_q[bds_pkg::DivNW-1]};
    diff  = trial - {1'b0, divisor_i};
    fits  = trial >= {1'b0, divisor_i};
    rem_d = fits ? diff[bds_pkg::DivDW-1:0] : trial[bds_pkg::DivDW-1:0];
    quo_d = {quo_q[bds_pkg::DivNW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= bds_pkg::DivCntW'(bds_pkg::DivNW);
    end else if (busy_q) begin
      busy_q <= (cnt_q != bds_pkg::DivCntW'(1));
      cnt_q  <= cnt_q - bds_pkg::DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== rtl/core/bds_datapath.sv =====
module bds_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [bds_pkg::DimW-1:0]   cfg_data_i,
  input  logic [bds_pkg::PixW-1:0]   red_in_i,
  input  logic [bds_pkg::PixW-1:0]   green_in_i,
  input  logic [bds_pkg::PixW-1:0]   blue_in_i,
  input  logic                       out_stall_i,
  input  bds_pkg::ctrl_cmd_t         cmd_i,
  output bds_pkg::dp_status_t        status_o,
  output logic                       out_valid_o,
  output logic [bds_pkg::PixW-1:0]   red_out_o,
  output logic [bds_pkg::PixW-1:0]   green_out_o,
  output logic [bds_pkg::PixW-1:0]   blue_out_o,
  output logic [bds_pkg::PosW-1:0]   out_col_o,
  output logic [bds_pkg::PosW-1:0]   out_row_o,
  output logic                       frame_done_o
);

  // Configuration and derived frame geometry
  logic [bds_pkg::DimW-1:0]  fw_q, fh_q;
  logic [bds_pkg::FactW-1:0] sf_q;
  logic [bds_pkg::DimW-1:0]  w, h;
  logic [bds_pkg::FactW-1:0] f;
  logic [bds_pkg::CntW-1:0]  fm1;
  logic [bds_pkg::AreaW-1:0] area;
  logic [bds_pkg::DimW-1:0]  ow_q, oh_q;
  logic [bds_pkg::CntW-1:0]  skip_q;
  logic                      cfg_hit;

  // Stream position
  logic [bds_pkg::PosW-1:0] in_col_q, in_row_q, x_q, orow_q;
  logic [bds_pkg::CntW-1:0] cx_q, rib_q;
  logic row_end, frame_end, row_used, col_used, is_first, is_last, is_done;

  // Per-item hold
  logic [2:0][bds_pkg::PixW-1:0] px_q;
  logic [bds_pkg::PosW-1:0]      slot_q, col_q, row_q;
  logic                          first_q, last_q, done_q;

  // Sums, divider, result
  logic [2:0][bds_pkg::SumW-1:0] rd_sum, sum_d, sum_q;
  logic [bds_pkg::RamW-1:0]      ram_rdata;
  logic [bds_pkg::DivNW-1:0]     dividend, quotient;
  logic [bds_pkg::DivDW-1:0]     divisor, remainder;
  logic                          div_busy;
  logic [2:0][bds_pkg::PixW-1:0] avg_q;
  logic                          out_valid_q;
  logic [bds_pkg::PixW-1:0]      red_q, green_q, blue_q;
  logic [bds_pkg::PosW-1:0]      ocol_q, orow_out_q;
  logic                          fdone_q;

  assign cfg_hit = cfg_we_i && (cfg_idx_i == bds_pkg::REG_WIDTH ||
                                cfg_idx_i == bds_pkg::REG_HEIGHT ||
                                cfg_idx_i == bds_pkg::REG_FACTOR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= bds_pkg::WidthReset;
      fh_q <= bds_pkg::HeightReset;
      sf_q <= bds_pkg::FactorReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bds_pkg::REG_WIDTH) begin
        fw_q <= cfg_data_i;
      end
      if (cfg_idx_i == bds_pkg::REG_HEIGHT) begin
        fh_q <= cfg_data_i;
      end
      if (cfg_idx_i == bds_pkg::REG_FACTOR) begin
        sf_q <= cfg_data_i[bds_pkg::FactW-1:0];
      end
    end
  end

  // Clamp registers to their working ranges
  always_comb begin
    w = (fw_q == '0) ? bds_pkg::DimW'(1) :
        (fw_q > bds_pkg::DimW'(bds_pkg::MaxWidth)) ? bds_pkg::DimW'(bds_pkg::MaxWidth) : fw_q;
    h = (fh_q == '0) ? bds_pkg::DimW'(1) :
        (fh_q > bds_pkg::DimW'(bds_pkg::HeightLimit)) ? bds_pkg::DimW'(bds_pkg::HeightLimit)
                                                      : fh_q;
    f = (sf_q == '0) ? bds_pkg::FactW'(1) :
        (sf_q > bds_pkg::FactW'(bds_pkg::MaxFactor)) ? bds_pkg::FactW'(bds_pkg::MaxFactor)
                                                     : sf_q;
    fm1  = bds_pkg::CntW'(f - bds_pkg::FactW'(1));
    area = {4'b0, f} * {4'b0, f};
  end

  always_comb begin
    row_end   = {1'b0, in_col_q} == (w - bds_pkg::DimW'(1));
    frame_end = {1'b0, in_row_q} == (h - bds_pkg::DimW'(1));
    row_used  = (oh_q != '0) && (in_row_q >= {8'b0, skip_q});
    col_used  = {1'b0, x_q} < ow_q;
    is_first  = (rib_q == '0) && (cx_q == '0);
    is_last   = (rib_q == fm1) && (cx_q == fm1);
    is_done   = (orow_q == '0) && ({1'b0, x_q} == (ow_q - bds_pkg::DimW'(1)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ow_q   <= '0;
      oh_q   <= '0;
      skip_q <= '0;
    end else if (cmd_i.div_capture) begin
      if (cmd_i.div_op == bds_pkg::OP_WIDTH) begin
        ow_q <= quotient[bds_pkg::DimW-1:0];
      end
      if (cmd_i.div_op == bds_pkg::OP_HEIGHT) begin
        oh_q   <= quotient[bds_pkg::DimW-1:0];
        skip_q <= remainder[bds_pkg::CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
      x_q      <= '0;
      cx_q     <= '0;
      rib_q    <= '0;
      orow_q   <= '0;
    end else if (cfg_hit) begin
      in_col_q <= '0;
      in_row_q <= '0;
      x_q      <= '0;
      cx_q     <= '0;
      rib_q    <= '0;
    end else begin
      if (cmd_i.accept) begin
        if (row_end) begin
          in_col_q <= '0;
          x_q      <= '0;
          cx_q     <= '0;
          if (frame_end) begin
            in_row_q <= '0;
            rib_q    <= '0;
            orow_q   <= oh_q[bds_pkg::PosW-1:0] - bds_pkg::PosW'(1);
          end else begin
            in_row_q <= in_row_q + bds_pkg::PosW'(1);
            if (row_used) begin
              if (rib_q == fm1) begin
                rib_q  <= '0;
                orow_q <= orow_q - bds_pkg::PosW'(1);
              end else begin
                rib_q <= rib_q + bds_pkg::CntW'(1);
              end
            end
          end
        end else begin
          in_col_q <= in_col_q + bds_pkg::PosW'(1);
          if (cx_q == fm1) begin
            cx_q <= '0;
            x_q  <= x_q + bds_pkg::PosW'(1);
          end else begin
            cx_q <= cx_q + bds_pkg::CntW'(1);
          end
        end
      end
      if (cmd_i.div_capture && cmd_i.div_op == bds_pkg::OP_HEIGHT) begin
        orow_q <= quotient[bds_pkg::PosW-1:0] - bds_pkg::PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      px_q    <= {blue_in_i, green_in_i, red_in_i};
      slot_q  <= x_q;
      first_q <= is_first;
      last_q  <= is_last;
      col_q   <= x_q;
      row_q   <= orow_q;
      done_q  <= is_done;
    end
  end

  // Line buffer of per-column block sums
  assign rd_sum = ram_rdata;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_d[c] = first_q ? {8'b0, px_q[c]} : rd_sum[c] + {8'b0, px_q[c]};
    end
  end

  bds_ram #(
    .Width (bds_pkg::RamW),
    .Depth (bds_pkg::MaxWidth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (slot_q[bds_pkg::RamAw-1:0]),
    .wdata_i (sum_d),
    .raddr_i (x_q[bds_pkg::RamAw-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.ram_we) begin
      sum_q <= sum_d;
    end
  end

  // Shared divider: frame geometry after a restart, block averages per result
  always_comb begin
    unique case (cmd_i.div_op)
      bds_pkg::OP_WIDTH: begin
        dividend = {3'b0, w};
        divisor  = {8'b0, f};
      end
      bds_pkg::OP_HEIGHT: begin
        dividend = {3'b0, h};
        divisor  = {8'b0, f};
      end
      bds_pkg::OP_RED: begin
        dividend = sum_q[0];
        divisor  = {4'b0, area};
      end
      bds_pkg::OP_GREEN: begin
        dividend = sum_q[1];
        divisor  = {4'b0, area};
      end
      bds_pkg::OP_BLUE: begin
        dividend = sum_q[2];
        divisor  = {4'b0, area};
      end
      default: begin
        dividend = '0;
        divisor  = {8'b0, f};
      end
    endcase
  end

  bds_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (dividend),
    .divisor_i   (divisor),
    .busy_o      (div_busy),
    .quotient_o  (quotient),
    .remainder_o (remainder)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_capture) begin
      if (cmd_i.div_op == bds_pkg::OP_RED) begin
        avg_q[0] <= quotient[bds_pkg::PixW-1:0];
      end
      if (cmd_i.div_op == bds_pkg::OP_GREEN) begin
        avg_q[1] <= quotient[bds_pkg::PixW-1:0];
      end
      if (cmd_i.div_op == bds_pkg::OP_BLUE) begin
        avg_q[2] <= quotient[bds_pkg::PixW-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      red_q      <= avg_q[0];
      green_q    <= avg_q[1];
      blue_q     <= avg_q[2];
      ocol_q     <= col_q;
      orow_out_q <= row_q;
      fdone_q    <= done_q;
    end
  end

  always_comb begin
    status_o.cfg_hit  = cfg_hit;
    status_o.pix_used = row_used && col_used;
    status_o.last     = last_q;
    status_o.div_busy = div_busy;
    status_o.out_free = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = red_q;
  assign green_out_o  = green_q;
  assign blue_out_o   = blue_q;
  assign out_col_o    = ocol_q;
  assign out_row_o    = orow_out_q;
  assign frame_done_o = fdone_q;

endmodule

// ===== rtl/core/bds_ctrl.sv =====
module bds_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                cfg_we_i,
  input  bds_pkg::dp_status_t status_i,
  output bds_pkg::ctrl_cmd_t  cmd_o,
  output logic                in_stall_o
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_ACC   = 9'b000000010,
    ST_CGO   = 9'b000000100,
    ST_CWAIT = 9'b000001000,
    ST_OUT   = 9'b000010000,
    ST_WGO   = 9'b000100000,
    ST_WWAIT = 9'b001000000,
    ST_HGO   = 9'b010000000,
    ST_HWAIT = 9'b100000000
  } state_e;

  state_e           state_q, state_d;
  bds_pkg::div_op_e op_q, op_d;
  logic             idle_take;

  assign idle_take  = (state_q == ST_IDLE) && !cfg_we_i;
  assign in_stall_o = !idle_take;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.div_op = op_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i && idle_take;
        if (cmd_o.accept && status_i.pix_used) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.ram_we = 1'b1;
        if (status_i.last) begin
          op_d    = bds_pkg::OP_RED;
          state_d = ST_CGO;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CGO: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_CWAIT;
      end
      ST_CWAIT: begin
        if (!status_i.div_busy) begin
          cmd_o.div_capture = 1'b1;
          unique case (op_q)
            bds_pkg::OP_RED: begin
              op_d    = bds_pkg::OP_GREEN;
              state_d = ST_CGO;
            end
            bds_pkg::OP_GREEN: begin
              op_d    = bds_pkg::OP_BLUE;
              state_d = ST_CGO;
            end
            default: begin
              state_d = ST_OUT;
            end
          endcase
        end
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_WGO: begin
        cmd_o.div_op    = bds_pkg::OP_WIDTH;
        cmd_o.div_start = 1'b1;
        state_d = ST_WWAIT;
      end
      ST_WWAIT: begin
        cmd_o.div_op = bds_pkg::OP_WIDTH;
        if (!status_i.div_busy) begin
          cmd_o.div_capture = 1'b1;
          state_d = ST_HGO;
        end
      end
      ST_HGO: begin
        cmd_o.div_op    = bds_pkg::OP_HEIGHT;
        cmd_o.div_start = 1'b1;
        state_d = ST_HWAIT;
      end
      ST_HWAIT: begin
        cmd_o.div_op = bds_pkg::OP_HEIGHT;
        if (!status_i.div_busy) begin
          cmd_o.div_capture = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_WGO;
      end
    endcase
    // A register write restarts the frame and recomputes its geometry
    if (status_i.cfg_hit) begin
      state_d = ST_WGO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WGO;
      op_q    <= bds_pkg::OP_RED;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

// ===== rtl/core/box_downsample_with_row_flip.sv =====
// An item outside any block is taken without leaving idle; one inside a block also has its
// line buffer entry read, then written. A block's last item then runs three divisions in the
// shared bit-serial divider and loads the output register, and the next item is taken only
// after that load, so the divider sets the rate.
// Reset (rst_ni low, asynchronous) loads 640x480, factor 1; after reset and after
// every register write the input stalls while width and height are divided.
module box_downsample_with_row_flip (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write port
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [bds_pkg::DimW-1:0]  cfg_data_i,
  // Input pixel item
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [bds_pkg::PixW-1:0]  red_in_i,
  input  logic [bds_pkg::PixW-1:0]  green_in_i,
  input  logic [bds_pkg::PixW-1:0]  blue_in_i,
  // Output pixel item
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [bds_pkg::PixW-1:0]  red_out_o,
  output logic [bds_pkg::PixW-1:0]  green_out_o,
  output logic [bds_pkg::PixW-1:0]  blue_out_o,
  output logic [bds_pkg::PosW-1:0]  out_col_o,
  output logic [bds_pkg::PosW-1:0]  out_row_o,
  output logic                      frame_done_o
);

  // The controller sequences one item at a time: accept, accumulate into the
  // line buffer entry of its block column, and on the last pixel of a block run
  // the three channel divisions. The finished result sits in the output register,
  // so the next item is taken while it waits for the sink.
  bds_pkg::ctrl_cmd_t  cmd;
  bds_pkg::dp_status_t status;

  bds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cfg_we_i   (cfg_we_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // The datapath owns the registers, the frame counters, the line buffer of
  // column sums (each block's first pixel overwrites its entry, so the buffer
  // needs no clearing), the divider and the output register.
  bds_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .out_stall_i  (out_stall_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .out_col_o    (out_col_o),
    .out_row_o    (out_row_o),
    .frame_done_o (frame_done_o)
  );

endmodule

// ===== rtl/core/bds_checker.sv =====
module bds_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_we_i,
  input logic [1:0]                cfg_idx_i,
  input logic [bds_pkg::DimW-1:0]  cfg_data_i,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic [bds_pkg::PixW-1:0]  red_in_i,
  input logic [bds_pkg::PixW-1:0]  green_in_i,
  input logic [bds_pkg::PixW-1:0]  blue_in_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [bds_pkg::PixW-1:0]  red_out_o,
  input logic [bds_pkg::PixW-1:0]  green_out_o,
  input logic [bds_pkg::PixW-1:0]  blue_out_o,
  input logic [bds_pkg::PosW-1:0]  out_col_o,
  input logic [bds_pkg::PosW-1:0]  out_row_o,
  input logic                      frame_done_o
);

  // A held result stays presented
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(red_out_o) && $stable(green_out_o) &&
      $stable(blue_out_o) && $stable(out_col_o) && $stable(out_row_o))
    else $error("stalled result changed");

  // The last result of a frame lies in the top output row
  a_done_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> out_row_o == '0)
    else $error("frame end flagged off the top row");

  // A register write restarts the frame and holds off input items
  a_cfg_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == bds_pkg::REG_WIDTH || cfg_idx_i == bds_pkg::REG_HEIGHT ||
                 cfg_idx_i == bds_pkg::REG_FACTOR) |=> in_stall_o)
    else $error("input taken right after a register write");

endmodule

bind box_downsample_with_row_flip bds_checker u_bds_checker (.*);

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bds_pkg::*;

  // Generous bound on the whole run; the slowest legal run is far below it
  localparam int unsigned CycleLimit   = 2_000_000;
  // Idle cycles after the last result before touching the registers or ending
  localparam int unsigned SettleCycles = 100;
  // Length of the long receiver hold-off that backs the block up
  localparam int unsigned HoldCycles   = 3000;
  localparam int unsigned RandItems    = 1800;

  typedef struct {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
    int unsigned     gap;
  } pix_item_t;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
    logic [PosW-1:0] col;
    logic [PosW-1:0] row;
    logic            done;
  } avg_pix_t;

  // DUT stimulus, all known from time zero
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [1:0]       cfg_idx_i   = REG_WIDTH;
  logic [DimW-1:0]  cfg_data_i  = '0;
  logic             in_valid_i  = 1'b0;
  logic [PixW-1:0]  red_in_i    = '0;
  logic [PixW-1:0]  green_in_i  = '0;
  logic [PixW-1:0]  blue_in_i   = '0;
  logic             out_stall_i = 1'b0;

  logic             in_stall_o;
  logic             out_valid_o;
  logic [PixW-1:0]  red_out_o;
  logic [PixW-1:0]  green_out_o;
  logic [PixW-1:0]  blue_out_o;
  logic [PosW-1:0]  out_col_o;
  logic [PosW-1:0]  out_row_o;
  logic             frame_done_o;

  // Pending input pixels and predicted block averages, oldest first
  pix_item_t   pixel_q[$];
  avg_pix_t    block_avg_q[$];

  // Shadow of the configuration registers
  logic [DimW-1:0]  shadow_width  = WidthReset;
  logic [DimW-1:0]  shadow_height = HeightReset;
  logic [FactW-1:0] shadow_factor = FactorReset;

  // Shadow of the line buffer and the frame position
  int unsigned sum_red   [MaxWidth];
  int unsigned sum_green [MaxWidth];
  int unsigned sum_blue  [MaxWidth];
  int unsigned pos_col   = 0;
  int unsigned pos_row   = 0;
  int unsigned blk_row   = 0;

  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_cnt   = 0;
  int unsigned rx_wait   = 0;
  int unsigned hold_left = 0;
  logic        hold_kick = 1'b0;
  bit          tx_idle   = 1'b1;
  bit          rx_idle   = 1'b1;

  box_downsample_with_row_flip i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .out_col_o   (out_col_o),
    .out_row_o   (out_row_o),
    .frame_done_o(frame_done_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned fit(input int unsigned v, input int unsigned lo,
                                      input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the shadow frame by one pixel; push a block average when the
  // pixel closes its block.
  function automatic void accumulate_pixel(input logic [PixW-1:0] r,
                                           input logic [PixW-1:0] g,
                                           input logic [PixW-1:0] b);
    int unsigned w, h, f, ow, oh, skip, x, cx, area, orow;
    bit          used, first;
    avg_pix_t    res;
    w    = fit(32'(shadow_width), 1, MaxWidth);
    h    = fit(32'(shadow_height), 1, HeightLimit);
    f    = fit(32'(shadow_factor), 1, MaxFactor);
    ow   = w / f;
    oh   = h / f;
    skip = h - oh * f;
    // Leftover bottom rows arrive first and are dropped
    used = (oh > 0) && (pos_row >= skip);
    if (used && pos_col < ow * f) begin
      x     = pos_col / f;
      cx    = pos_col - x * f;
      first = (blk_row == 0) && (cx == 0);
      // The first pixel of a block overwrites its column entry
      sum_red[x]   = first ? 32'(r) : sum_red[x] + 32'(r);
      sum_green[x] = first ? 32'(g) : sum_green[x] + 32'(g);
      sum_blue[x]  = first ? 32'(b) : sum_blue[x] + 32'(b);
      if (blk_row == f - 1 && cx == f - 1) begin
        area      = f * f;
        orow      = (h - 1 - pos_row) / f;
        res.red   = PixW'(sum_red[x] / area);
        res.green = PixW'(sum_green[x] / area);
        res.blue  = PixW'(sum_blue[x] / area);
        res.col   = PosW'(x);
        res.row   = PosW'(orow);
        res.done  = (orow == 0) && (x == ow - 1);
        block_avg_q.push_back(res);
      end
    end
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      if (used) blk_row = (blk_row + 1 >= f) ? 0 : blk_row + 1;
      pos_row++;
      if (pos_row >= h) begin
        pos_row = 0;
        blk_row = 0;
      end
    end
  endfunction

  function automatic void add_pixel(input logic [PixW-1:0] r, input logic [PixW-1:0] g,
                                    input logic [PixW-1:0] b);
    pix_item_t it;
    it.red   = r;
    it.green = g;
    it.blue  = b;
    it.gap   = tx_idle ? $urandom_range(0, 15) : 0;
    pixel_q.push_back(it);
  endfunction

  // Random channel value, biased toward the rails so block sums get large
  function automatic logic [PixW-1:0] rand_chan();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return PixW'($urandom_range(0, 255));
  endfunction

  function automatic void add_rand_pixels(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) add_pixel(rand_chan(), rand_chan(), rand_chan());
  endfunction

  // Hold until every pixel is taken and every average has come back, then let
  // the block drain items that produce no result.
  task automatic wait_idle();
    while (pixel_q.size() != 0 || block_avg_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DimW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    // The write took at this edge: mirror it and restart the frame
    case (idx)
      REG_WIDTH:  shadow_width  = val;
      REG_HEIGHT: shadow_height = val;
      REG_FACTOR: shadow_factor = val[FactW-1:0];
      default: ;
    endcase
    pos_col = 0;
    pos_row = 0;
    blk_row = 0;
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned f);
    wait_idle();
    write_reg(REG_WIDTH, DimW'(w));
    write_reg(REG_HEIGHT, DimW'(h));
    write_reg(REG_FACTOR, DimW'(f));
  endtask

  // Driver: offer the head of pixel_q after its gap, drop it once accepted
  always @(posedge clk_i or negedge rst_ni) begin : drv_blk
    logic offer;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      red_in_i   <= '0;
      green_in_i <= '0;
      blue_in_i  <= '0;
      gap_cnt    <= 0;
    end else begin
      offer = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        accumulate_pixel(red_in_i, green_in_i, blue_in_i);
        void'(pixel_q.pop_front());
        offer = 1'b0;
      end
      if (!offer && pixel_q.size() != 0) begin
        if (gap_cnt < pixel_q[0].gap) begin
          gap_cnt <= gap_cnt + 1;
        end else begin
          red_in_i   <= pixel_q[0].red;
          green_in_i <= pixel_q[0].green;
          blue_in_i  <= pixel_q[0].blue;
          gap_cnt    <= 0;
          offer = 1'b1;
        end
      end
      in_valid_i <= offer;
    end
  end

  // Long receiver hold-off, counted here and kicked from the stimulus
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each accepted result against the oldest prediction,
  // then stall for a drawn number of cycles
  always @(posedge clk_i or negedge rst_ni) begin : mon_blk
    int unsigned wait_next;
    avg_pix_t    want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait     <= 0;
    end else begin
      wait_next = rx_wait;
      if (out_valid_o && !out_stall_i) begin
        if (block_avg_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result: col %0d row %0d rgb %0d %0d %0d done %0d",
                     out_col_o, out_row_o, red_out_o, green_out_o, blue_out_o,
                     frame_done_o);
        end else begin
          want = block_avg_q.pop_front();
          if (red_out_o !== want.red || green_out_o !== want.green ||
              blue_out_o !== want.blue || out_col_o !== want.col ||
              out_row_o !== want.row || frame_done_o !== want.done) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: expected col %0d row %0d rgb %0d %0d %0d done %0d, %s",
                       want.col, want.row, want.red, want.green, want.blue, want.done,
                       $sformatf("got col %0d row %0d rgb %0d %0d %0d done %0d",
                                 out_col_o, out_row_o, red_out_o, green_out_o,
                                 blue_out_o, frame_done_o));
          end
        end
        wait_next = rx_idle ? $urandom_range(0, 15) : 0;
      end else if (wait_next != 0) begin
        wait_next--;
      end
      rx_wait     <= wait_next;
      out_stall_i <= (wait_next != 0) || (hold_left != 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stim_blk
    int unsigned sent, pick, w, h, f, cw, ch, cf, frame, n;
    sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry 640x480, factor 1: every pixel is its own block
    add_pixel(8'h00, 8'h00, 8'h00);
    add_pixel(8'hFF, 8'hFF, 8'hFF);
    add_pixel(8'hAA, 8'h55, 8'h0F);
    add_pixel(8'h55, 8'hAA, 8'hF0);

    // One 2x2 block; the last pixel pulls the sum just below a whole multiple
    set_frame(2, 2, 2);
    add_pixel(8'hFF, 8'hFF, 8'hFF);
    add_pixel(8'hFF, 8'h00, 8'hFF);
    add_pixel(8'hFF, 8'hFF, 8'h00);
    add_pixel(8'hFE, 8'h01, 8'h01);

    // Leftover bottom row and right column dropped
    set_frame(3, 3, 2);
    add_rand_pixels(9);

    // Factor larger than the frame: pixels counted, nothing out
    set_frame(3, 1, 4);
    add_rand_pixels(3);

    // Zero registers act as one
    set_frame(0, 0, 0);
    add_rand_pixels(2);

    // Height saturates: bottom output rows of a one-pixel-wide column
    set_frame(1, 8191, 1);
    add_rand_pixels(2);

    // Back the block up: receiver holds off while the sender keeps offering
    set_frame(8, 8, 1);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    add_rand_pixels(192);
    sent += 192;
    @(posedge clk_i);
    hold_kick <= 1'b1;
    @(posedge clk_i);
    hold_kick <= 1'b0;

    while (sent < RandItems) begin
      pick = $urandom_range(0, 19);
      n    = 0;
      if (pick < 12) begin
        f = $urandom_range(1, 4);
        w = $urandom_range(1, 20);
        h = $urandom_range(1, 12);
      end else if (pick < 15) begin
        f = $urandom_range(5, 16);
        w = $urandom_range(f, f + 6);
        h = $urandom_range(f, f + 2);
      end else if (pick < 16) begin
        // Factor out of range: zero acts as one, large saturates
        if ($urandom_range(0, 1)) begin
          f = 0;
          w = $urandom_range(1, 6);
          h = $urandom_range(1, 6);
        end else begin
          f = $urandom_range(17, 31);
          w = $urandom_range(16, 20);
          h = $urandom_range(16, 17);
        end
      end else if (pick < 17) begin
        // Factor larger than one dimension
        f = $urandom_range(2, 16);
        if ($urandom_range(0, 1)) begin
          w = $urandom_range(1, f - 1);
          h = $urandom_range(1, 20);
        end else begin
          w = $urandom_range(1, 20);
          h = $urandom_range(1, f - 1);
        end
        n = $urandom_range(1, 30);
      end else if (pick < 18) begin
        // Widest frames, a partial first row only
        w = $urandom_range(0, 1) ? MaxWidth : $urandom_range(MaxWidth + 1, 8191);
        h = $urandom_range(1, 3);
        f = $urandom_range(1, 2);
        n = $urandom_range(20, 60);
      end else begin
        // Zero width or height, or tallest frames with a partial run of rows
        w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
        h = $urandom_range(0, 1) ? 0 : $urandom_range(HeightLimit, 8191);
        f = $urandom_range(1, 3);
        n = $urandom_range(20, 60);
      end
      cw    = fit(w, 1, MaxWidth);
      ch    = fit(h, 1, HeightLimit);
      cf    = fit(f, 1, MaxFactor);
      frame = cw * ch;
      if (n == 0) begin
        // Whole frames mostly, sometimes cut short by the next register write
        if ($urandom_range(0, 3) == 0) n = $urandom_range(1, 2 * frame);
        else n = frame * $urandom_range(1, 3);
        if (n > 400) n = 400;
      end
      set_frame(w, h, f);
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      add_rand_pixels(n);
      if (cw >= cf && ch >= cf) sent += n;
    end

    wait_idle();
    if (err_cnt == 0 && block_avg_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
